>>> sv/cdsr_pkg.sv
// Package for the clipped disc span rasterizer.
// Holds default sizes, register indexes and the controller/datapath command
// and status structs. No dependencies.
package cdsr_pkg;

    localparam int MAX_BOX_DEF    = 64;
    localparam int COORD_BITS_DEF = 12;
    localparam int SIZE_BITS      = 7;
    localparam int CFG_IDX_BITS   = 1;
    localparam int LIMIT_RESET    = 4096;

    localparam logic [CFG_IDX_BITS-1:0] REG_MAP_COLS = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAP_ROWS = 1'b1;

    typedef struct packed {
        logic load;       // capture a new disc request
        logic init;       // set up squares and scan counters
        logic inc_h;      // grow the half-width by one
        logic dec_h;      // shrink the half-width by one
        logic step_row;   // evaluate current row and advance
        logic push_last;  // move the pending span out as the final one
    } t_cmd;

    typedef struct packed {
        logic row_end;    // all box rows scanned
        logic need_inc;   // half-width too small for this row
        logic need_dec;   // half-width too large for this row
        logic span_ok;    // current row gives a non-empty clipped span
        logic pend_vld;   // a span waits in the pending register
        logic slot_free;  // output register can take an item this cycle
    } t_sts;

endpackage

>>> sv/cdsr_ctrl.sv
// Controller for the clipped disc span rasterizer.
// Sequences load, setup, row scan and final flush; uses cdsr_pkg.
module cdsr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  cdsr_pkg::t_sts  i_sts,
    output cdsr_pkg::t_cmd  o_cmd
);
    import cdsr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_FLUSH
    } t_state;

    t_state r_state, n_state;
    logic   r_ready;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (r_ready && i_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_INIT;
                end
            end
            S_INIT: begin
                cmd.init = 1'b1;
                n_state  = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.row_end) begin
                    n_state = i_sts.pend_vld ? S_FLUSH : S_IDLE;
                end else if (i_sts.need_inc) begin
                    cmd.inc_h = 1'b1;
                end else if (i_sts.need_dec) begin
                    cmd.dec_h = 1'b1;
                end else if (!(i_sts.span_ok && i_sts.pend_vld && !i_sts.slot_free)) begin
                    // stall only when a pending span must move out and cannot
                    cmd.step_row = 1'b1;
                end
            end
            S_FLUSH: begin
                if (i_sts.slot_free) begin
                    cmd.push_last = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_ready = r_ready;
    assign o_cmd   = cmd;

endmodule

>>> sv/cdsr_dpath.sv
// Datapath for the clipped disc span rasterizer.
// Incremental half-width tracking, span clipping, pending and output
// registers; driven by cdsr_ctrl commands, uses cdsr_pkg.
module cdsr_dpath #(
    parameter int MAX_BOX    = cdsr_pkg::MAX_BOX_DEF,
    parameter int COORD_BITS = cdsr_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cdsr_pkg::t_cmd                i_cmd,
    output cdsr_pkg::t_sts                o_sts,
    input  logic [COORD_BITS-1:0]         i_center_col,
    input  logic [COORD_BITS-1:0]         i_center_row,
    input  logic [cdsr_pkg::SIZE_BITS-1:0] i_box_size,
    input  logic [COORD_BITS:0]           i_col_lim,
    input  logic [COORD_BITS:0]           i_row_lim,
    input  logic                          i_out_ready,
    output logic                          o_valid,
    output logic [COORD_BITS-1:0]         o_span_row,
    output logic [COORD_BITS-1:0]         o_span_first,
    output logic [COORD_BITS-1:0]         o_span_final,
    output logic                          o_is_last
);
    import cdsr_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int SB   = $clog2(MAX_BOX + 1);
    localparam int RB   = $clog2(MAX_BOX / 2 + 1);
    localparam int QB   = 2 * RB + 1;
    localparam int CW   = CB + 2;
    localparam int CMPW = (SB > SIZE_BITS) ? SB : SIZE_BITS;

    logic [SB-1:0] r_s, r_y;
    logic [RB-1:0] r_r, r_h;
    logic [QB-1:0] r_r2, r_h2, r_dy2;
    logic [CB-1:0] r_ccol, r_crow;
    logic          r_pend_vld;
    logic [CB-1:0] r_pend_row, r_pend_lo, r_pend_hi;
    logic          r_out_vld, r_out_last;
    logic [CB-1:0] r_out_row, r_out_lo, r_out_hi;

    // request size, clamped to the box limit
    logic [SB-1:0] s_in;
    always_comb begin
        if (CMPW'(i_box_size) > CMPW'(MAX_BOX)) begin
            s_in = SB'(MAX_BOX);
        end else begin
            s_in = SB'(i_box_size);
        end
    end

    logic [QB-1:0] rad_ext, rad_sq, h_ext, h_twice, hp2, hm2;
    assign rad_ext = QB'(r_r);
    assign rad_sq  = rad_ext * rad_ext;
    assign h_ext   = QB'(r_h);
    assign h_twice = h_ext << 1;
    assign hp2     = r_h2 + h_twice + QB'(1);
    assign hm2     = r_h2 - h_twice + QB'(1);

    logic [QB:0] sum_inc, sum_cur;
    assign sum_inc = (QB+1)'(hp2) + (QB+1)'(r_dy2);
    assign sum_cur = (QB+1)'(r_h2) + (QB+1)'(r_dy2);

    // dy = y - r; next dy^2 = dy^2 + 2*dy + 1
    logic signed [SB:0] dy;
    logic signed [QB:0] dy2_next;
    assign dy       = $signed({1'b0, r_y}) - $signed((SB+1)'(r_r));
    assign dy2_next = $signed({1'b0, r_dy2}) + ((QB+1)'(dy) <<< 1) + (QB+1)'(1);

    // span of the current row in map coordinates, then clipped
    logic signed [CW-1:0] ccol_s, crow_s, h_s, rad_s, s_s, y_s;
    logic signed [CW-1:0] mx_lo, hi_a, hi_b, mx_hi, lo_c, hi_c, col_max, my;
    logic                 row_ok;
    always_comb begin
        ccol_s  = $signed(CW'(r_ccol));
        crow_s  = $signed(CW'(r_crow));
        h_s     = $signed(CW'(r_h));
        rad_s   = $signed(CW'(r_r));
        s_s     = $signed(CW'(r_s));
        y_s     = $signed(CW'(r_y));
        mx_lo   = ccol_s - h_s;
        hi_a    = ccol_s + h_s;
        // even sizes lose the rightmost column
        hi_b    = ccol_s - rad_s + s_s - CW'(1);
        mx_hi   = (hi_a < hi_b) ? hi_a : hi_b;
        lo_c    = (mx_lo < 0) ? '0 : mx_lo;
        col_max = $signed(CW'(i_col_lim)) - CW'(1);
        hi_c    = (mx_hi > col_max) ? col_max : mx_hi;
        my      = crow_s - rad_s + y_s;
        row_ok  = (my >= 0) && (my < $signed(CW'(i_row_lim)));
    end

    always_comb begin
        o_sts.row_end   = (r_y == r_s);
        o_sts.need_inc  = (sum_inc <= (QB+1)'(r_r2));
        o_sts.need_dec  = (r_h != '0) && (sum_cur > (QB+1)'(r_r2));
        o_sts.span_ok   = row_ok && (lo_c <= hi_c);
        o_sts.pend_vld  = r_pend_vld;
        o_sts.slot_free = !r_out_vld || i_out_ready;
    end

    logic push_pend;
    assign push_pend = (i_cmd.step_row && o_sts.span_ok && r_pend_vld) || i_cmd.push_last;

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.load || i_cmd.push_last) begin
                r_pend_vld <= 1'b0;
            end else if (i_cmd.step_row && o_sts.span_ok) begin
                r_pend_vld <= 1'b1;
            end
            if (push_pend) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload and scan state
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s    <= s_in;
            r_r    <= RB'(s_in >> 1);
            r_ccol <= i_center_col;
            r_crow <= i_center_row;
        end
        if (i_cmd.init) begin
            r_r2  <= rad_sq;
            r_dy2 <= rad_sq;
            r_h   <= '0;
            r_h2  <= '0;
            r_y   <= '0;
        end
        if (i_cmd.inc_h) begin
            r_h  <= r_h + RB'(1);
            r_h2 <= hp2;
        end
        if (i_cmd.dec_h) begin
            r_h  <= r_h - RB'(1);
            r_h2 <= hm2;
        end
        if (i_cmd.step_row) begin
            r_y   <= r_y + SB'(1);
            r_dy2 <= QB'(dy2_next);
            if (o_sts.span_ok) begin
                r_pend_row <= CB'(my);
                r_pend_lo  <= CB'(lo_c);
                r_pend_hi  <= CB'(hi_c);
            end
        end
        if (push_pend) begin
            r_out_row  <= r_pend_row;
            r_out_lo   <= r_pend_lo;
            r_out_hi   <= r_pend_hi;
            r_out_last <= i_cmd.push_last;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_span_row   = r_out_row;
    assign o_span_first = r_out_lo;
    assign o_span_final = r_out_hi;
    assign o_is_last    = r_out_last;

endmodule

>>> sv/clipped_disc_span_rasterizer.sv
// Clipped disc span rasterizer, top level: map size registers, clip limits,
// controller and datapath. Uses cdsr_pkg, cdsr_ctrl and cdsr_dpath.
//
// One disc request is taken at a time. Per request the block loads the
// request, sets up, scans the s box rows (s clamped to MAX_BOX) with
// half-width adjustments between them (at most 2*floor(s/2) over the whole
// disc, from the incremental square tracking), closes the scan and flushes
// the final span when there is one; it waits while a span must move out
// and the output side holds i_ready low. Spans come out in increasing row
// order through an output register, the last one flagged by o_is_last; a
// zero size or a disc wholly off the map gives none. Map width and height
// are for the user to write through the config port only while idle; the
// block does not enforce it. Limits above 2^COORD_BITS act as 2^COORD_BITS.
module clipped_disc_span_rasterizer #(
    parameter int MAX_BOX    = cdsr_pkg::MAX_BOX_DEF,
    parameter int COORD_BITS = cdsr_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cdsr_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [COORD_BITS:0]               i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [COORD_BITS-1:0]             i_center_col,
    input  logic [COORD_BITS-1:0]             i_center_row,
    input  logic [cdsr_pkg::SIZE_BITS-1:0]    i_box_size,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [COORD_BITS-1:0]             o_span_row,
    output logic [COORD_BITS-1:0]             o_span_first,
    output logic [COORD_BITS-1:0]             o_span_final,
    output logic                              o_is_last
);
    import cdsr_pkg::*;

    localparam int LB = COORD_BITS + 1;
    localparam logic [LB-1:0] LIM_CAP = LB'(1) << COORD_BITS;

    logic [LB-1:0] r_map_cols, r_map_rows;
    logic [LB-1:0] col_lim, row_lim;
    t_cmd          cmd;
    t_sts          sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_cols <= LB'(LIMIT_RESET);
            r_map_rows <= LB'(LIMIT_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MAP_COLS: r_map_cols <= i_cfg_data;
                REG_MAP_ROWS: r_map_rows <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign col_lim = (r_map_cols > LIM_CAP) ? LIM_CAP : r_map_cols;
    assign row_lim = (r_map_rows > LIM_CAP) ? LIM_CAP : r_map_rows;

    cdsr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    cdsr_dpath #(
        .MAX_BOX    (MAX_BOX),
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_center_col (i_center_col),
        .i_center_row (i_center_row),
        .i_box_size   (i_box_size),
        .i_col_lim    (col_lim),
        .i_row_lim    (row_lim),
        .i_out_ready  (i_ready),
        .o_valid      (o_valid),
        .o_span_row   (o_span_row),
        .o_span_first (o_span_first),
        .o_span_final (o_span_final),
        .o_is_last    (o_is_last)
    );

endmodule
